// File: rtl/rsu_pkg.sv
// Package for the range-sum block: command and engine state types, sizes.
// No dependencies; used by the front, queue and engine modules.
`default_nettype none
package rsu_pkg;

    // Input opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Index width: clamped range bounds never exceed the 11-bit range fields
    localparam int IDX_W = 11;

    // Command queue between front and engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_ADD,
        CMD_SUM,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   first;   // element index, or range start
        logic [IDX_W-1:0]   last;    // range end (exclusive)
        logic [31:0]        amount;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SUM,
        ST_DONE
    } eng_state_t;

endpackage
`default_nettype wire

// File: rtl/rsu_front.sv
// Front end: takes input words, drops no-ops, clamps ranges, builds commands.
// Depends on rsu_pkg.
`default_nettype none
module rsu_front
    import rsu_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
)
(
    input  wire logic        push,
    input  wire logic        q_full,
    input  wire logic [1:0]  op,
    input  wire logic [9:0]  position,
    input  wire logic [31:0] amount,
    input  wire logic [10:0] range_low,
    input  wire logic [10:0] range_end,
    output logic             q_push,
    output cmd_t             q_cmd
);

    logic [31:0] pos_w;
    logic [31:0] low_w;
    logic [31:0] end_w;
    logic [31:0] low_c;
    logic [31:0] end_c;
    logic        pos_ok;
    logic        keep;

    always_comb
    begin
        pos_w  = {22'd0, position};
        low_w  = {21'd0, range_low};
        end_w  = {21'd0, range_end};
        low_c  = (low_w > DEPTH) ? DEPTH : low_w;
        end_c  = (end_w > DEPTH) ? DEPTH : end_w;
        pos_ok = (pos_w < DEPTH);

        q_cmd.amount = amount;
        q_cmd.first  = low_c[IDX_W-1:0];
        q_cmd.last   = end_c[IDX_W-1:0];
        q_cmd.kind   = CMD_SUM;
        keep         = 1'b0;
        case (op)
            OP_LOAD:
            begin
                q_cmd.kind  = CMD_LOAD;
                q_cmd.first = {1'b0, position};
                keep        = pos_ok;
            end
            OP_ADD:
            begin
                q_cmd.kind  = CMD_ADD;
                q_cmd.first = {1'b0, position};
                keep        = pos_ok;
            end
            OP_QUERY:
            begin
                // inverted range checked before clamping
                q_cmd.kind = (range_low > range_end) ? CMD_REJECT : CMD_SUM;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
        q_push = push && !q_full && keep;
    end

endmodule
`default_nettype wire

// File: rtl/rsu_queue.sv
// Short command queue between front and engine.
// Depends on rsu_pkg.
`default_nettype none
module rsu_queue
    import rsu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  cmd_t      wr_cmd,
    input  wire logic rd_en,
    output cmd_t      rd_cmd,
    output logic      full,
    output logic      empty
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_wr;
    logic              do_rd;

    always_comb
    begin
        full        = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
        empty       = (count_reg == '0);
        do_wr       = wr_en && !full;
        do_rd       = rd_en && !empty;
        rd_cmd      = slot_reg[rd_ptr_reg];
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rsu_engine.sv
// Back end: element memory, add read-modify-write, range walk and result register.
// Depends on rsu_pkg.
`default_nettype none
module rsu_engine
    import rsu_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_empty,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    input  wire logic         pop,
    output logic              empty,
    output logic [63:0]       range_sum,
    output logic              bad_range
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]      mem [DEPTH];

    eng_state_t       state_reg;
    eng_state_t       state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic [IDX_W-1:0] hi_reg;
    logic [IDX_W-1:0] hi_next;
    logic [31:0]      amt_reg;
    logic [31:0]      amt_next;
    logic [63:0]      acc_reg;
    logic [63:0]      acc_next;
    logic             bad_reg;
    logic             bad_next;
    logic             pend_reg;
    logic             pend_next;
    logic [31:0]      rd_data_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [63:0]      out_sum_reg;
    logic             out_bad_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [31:0]      mem_wd;
    logic             mem_re;
    logic [AW-1:0]    mem_ra;
    logic             out_load;
    logic [63:0]      rd_ext;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        amt_next   = amt_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        pend_next  = 1'b0;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = AW'(cnt_reg);
        mem_wd     = rd_data_reg + amt_reg;
        mem_re     = 1'b0;
        mem_ra     = AW'(cnt_reg);
        out_load   = 1'b0;
        rd_ext     = {{32{rd_data_reg[31]}}, rd_data_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cnt_next = q_cmd.first;
                    hi_next  = q_cmd.last;
                    amt_next = q_cmd.amount;
                    acc_next = '0;
                    bad_next = 1'b0;
                    case (q_cmd.kind)
                        CMD_LOAD:
                        begin
                            mem_we = 1'b1;
                            mem_wa = AW'(q_cmd.first);
                            mem_wd = q_cmd.amount;
                        end
                        CMD_ADD:
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = AW'(q_cmd.first);
                            state_next = ST_ADD;
                        end
                        CMD_SUM:
                        begin
                            state_next = ST_SUM;
                        end
                        default:
                        begin
                            bad_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SUM:
            begin
                // one read issued per cycle, accumulated the cycle after
                if (pend_reg)
                begin
                    acc_next = acc_reg + rd_ext;
                end
                if (cnt_reg < hi_reg)
                begin
                    mem_re    = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        empty     = !out_valid_reg;
        range_sum = out_sum_reg;
        bad_range = out_bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        hi_reg  <= hi_next;
        amt_reg <= amt_next;
        acc_reg <= acc_next;
        bad_reg <= bad_next;
        if (out_load)
        begin
            out_sum_reg <= acc_reg;
            out_bad_reg <= bad_reg;
        end
    end

    // element memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

endmodule
`default_nettype wire

// File: rtl/range_sum_with_point_updates.sv
// Top level of the range-sum block with point loads and adds.
// Depends on rsu_pkg, rsu_front, rsu_queue and rsu_engine.
//
//   channel   handshake            word
//   -------   ------------------   ---------------------------------------------
//   input     push / full          op, position, amount, range_low, range_end
//   result    empty / pop          range_sum, bad_range (one per query)
//
// Per command: a load is one memory write, an add a memory read, then a write,
// and a query a walk over the range, then a hand-over of the result; the range
// walk reads one element per cycle from the single-port-read element memory.
// Inverted ranges skip the walk. The 4-entry command queue keeps input open
// while the engine walks a range.
// Reset clears the control state only; the element memory is not cleared and
// an element never written reads as garbage.
// full rises when the command queue is full; empty stays low until popped.
`default_nettype none
module range_sum_with_point_updates
    import rsu_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  op,
    input  wire logic [9:0]  position,
    input  wire logic [31:0] amount,
    input  wire logic [10:0] range_low,
    input  wire logic [10:0] range_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      range_sum,
    output logic             bad_range
);

    cmd_t  f_cmd;
    cmd_t  q_head;
    logic  f_push;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;

    assign full = q_full;

    // classify and clamp; ignored ops are accepted and dropped here
    rsu_front #(
        .DEPTH     (DEPTH)
    ) u_front (
        .push      (push),
        .q_full    (q_full),
        .op        (op),
        .position  (position),
        .amount    (amount),
        .range_low (range_low),
        .range_end (range_end),
        .q_push    (f_push),
        .q_cmd     (f_cmd)
    );

    // decouples input from the multi-cycle range walk
    rsu_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (f_push),
        .wr_cmd (f_cmd),
        .rd_en  (q_pop),
        .rd_cmd (q_head),
        .full   (q_full),
        .empty  (q_empty)
    );

    // executes commands in order against the element memory
    rsu_engine #(
        .DEPTH     (DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .range_sum (range_sum),
        .bad_range (bad_range)
    );

endmodule
`default_nettype wire
